### rtl/fms_pkg.sv
// ----------------------------------------------------------------------------
// fms_pkg
// shared constants and set identifiers for the three-set fuzzifier
// ----------------------------------------------------------------------------
package fms_pkg;

  localparam int VALUE_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int NUM_SETS          = 3;
  localparam int REG_INDEX_BITS    = 2;

  // set identifier, also the configuration register index of that set
  typedef enum logic [REG_INDEX_BITS-1:0] {
    SET_LOW  = 2'd0,
    SET_MID  = 2'd1,
    SET_HIGH = 2'd2
  } set_id_t;

endpackage

### rtl/fms_front.sv
// ----------------------------------------------------------------------------
// fms_front
// range tests per set, turns each degree into a numerator/denominator pair
// ----------------------------------------------------------------------------
module fms_front #(
  parameter int VALUE_BITS = fms_pkg::VALUE_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [VALUE_BITS-1:0]                             x,
  input  logic [fms_pkg::NUM_SETS-1:0][3*VALUE_BITS-1:0]    points,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [fms_pkg::NUM_SETS-1:0][VALUE_BITS:0]        out_rem,
  output logic [fms_pkg::NUM_SETS-1:0][VALUE_BITS-1:0]      out_den
);
  import fms_pkg::*;

  localparam logic [VALUE_BITS-1:0] ONE  = VALUE_BITS'(1);
  localparam logic [VALUE_BITS-1:0] ZERO = '0;

  logic [NUM_SETS-1:0][VALUE_BITS-1:0] num_next;
  logic [NUM_SETS-1:0][VALUE_BITS-1:0] den_next;

  for (genvar g = 0; g < NUM_SETS; g++) begin : g_set
    localparam set_id_t KIND = set_id_t'(g);

    logic [VALUE_BITS-1:0] a, b, c;
    logic [VALUE_BITS-1:0] up_n, up_d, dn_n, dn_d;
    logic [VALUE_BITS-1:0] num, den;
    logic                  in_ab, in_bc;

    always_comb begin
      a     = points[g][VALUE_BITS-1:0];
      b     = points[g][2*VALUE_BITS-1:VALUE_BITS];
      c     = points[g][3*VALUE_BITS-1:2*VALUE_BITS];
      in_ab = (x >= a) && (x <= b);
      in_bc = (x >= b) && (x <= c);
      up_n  = x - a;
      up_d  = b - a;
      dn_n  = c - x;
      dn_d  = c - b;
      num   = ZERO;
      den   = ONE;
      unique case (KIND)
        SET_LOW: begin
          if (in_bc) begin
            num = dn_n;
            den = dn_d;
          end else if (in_ab) begin
            num = ONE;
          end
        end
        SET_MID: begin
          if (in_ab) begin
            num = up_n;
            den = up_d;
          end else if (in_bc) begin
            num = dn_n;
            den = dn_d;
          end
        end
        SET_HIGH: begin
          if (in_ab) begin
            num = up_n;
            den = up_d;
          end else if (in_bc) begin
            num = ONE;
          end
        end
        default: begin
          num = ZERO;
          den = ONE;
        end
      endcase
      // a zero-width slope that matched reads as full membership
      if (den == ZERO) begin
        num = ONE;
        den = ONE;
      end
      num_next[g] = num;
      den_next[g] = den;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        out_rem[s] <= {1'b0, num_next[s]};
        out_den[s] <= den_next[s];
      end
    end
  end

endmodule

### rtl/fms_cell.sv
// ----------------------------------------------------------------------------
// fms_cell
// one restoring-division step for all three sets, one quotient bit per cell
// ----------------------------------------------------------------------------
module fms_cell #(
  parameter int VALUE_BITS    = fms_pkg::VALUE_BITS_DEF,
  parameter int FRACTION_BITS = fms_pkg::FRACTION_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [fms_pkg::NUM_SETS-1:0][VALUE_BITS:0]        in_rem,
  input  logic [fms_pkg::NUM_SETS-1:0][VALUE_BITS-1:0]      in_den,
  input  logic [fms_pkg::NUM_SETS-1:0][FRACTION_BITS:0]     in_quo,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [fms_pkg::NUM_SETS-1:0][VALUE_BITS:0]        out_rem,
  output logic [fms_pkg::NUM_SETS-1:0][VALUE_BITS-1:0]      out_den,
  output logic [fms_pkg::NUM_SETS-1:0][FRACTION_BITS:0]     out_quo
);
  import fms_pkg::*;

  logic [NUM_SETS-1:0][VALUE_BITS:0]    rem_next;
  logic [NUM_SETS-1:0][FRACTION_BITS:0] quo_next;

  always_comb begin
    logic             fit;
    logic [VALUE_BITS:0] diff;
    for (int s = 0; s < NUM_SETS; s++) begin
      fit         = in_rem[s] >= {1'b0, in_den[s]};
      diff        = fit ? (in_rem[s] - {1'b0, in_den[s]}) : in_rem[s];
      // diff stays below the divisor, so the shift cannot overflow
      rem_next[s] = {diff[VALUE_BITS-1:0], 1'b0};
      quo_next[s] = {in_quo[s][FRACTION_BITS-1:0], fit};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_rem <= rem_next;
      out_den <= in_den;
      out_quo <= quo_next;
    end
  end

endmodule

### rtl/fuzzy_membership_three_sets.sv
// ----------------------------------------------------------------------------
// fuzzy_membership_three_sets
// triangular fuzzifier: one crisp value in, degrees in low/mid/high sets out
// ----------------------------------------------------------------------------
// usage
//   cfg channel: register 0/1/2 holds the a,b,c breakpoints of the low,
//   middle and high set (a in the lowest field); write only while idle.
//   s_axis: one crisp value per transfer. m_axis: one transfer per value
//   carrying the three degrees, Q1.8 at default size (256 means 1.0).
// pipeline
//   one register for the range tests, then one cell per quotient bit in
//   the divider chain. one value is taken every cycle unless a stalled
//   receiver has backed up the chain.
// reset
//   all breakpoints clear to zero and every stage of the chain empties.
// stalls
//   each cell holds its own valid and moves on when the next one is free,
//   so a stalled receiver only backs up the chain once it is full; bubbles
//   are squeezed out and input keeps flowing until then.
// ----------------------------------------------------------------------------
module fuzzy_membership_three_sets #(
  parameter int VALUE_BITS    = fms_pkg::VALUE_BITS_DEF,
  parameter int FRACTION_BITS = fms_pkg::FRACTION_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // configuration write channel
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [fms_pkg::REG_INDEX_BITS-1:0]          cfg_index,
  input  logic [3*VALUE_BITS-1:0]                     cfg_data,
  // input stream
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]             s_tdata,  // crisp_value
  // result stream
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [((3*(FRACTION_BITS+1)+7)/8)*8-1:0]    m_tdata   // low_degree, mid_degree,
                                                                // high_degree
);
  import fms_pkg::*;

  localparam int CELLS  = FRACTION_BITS + 1;
  localparam int DEG_W  = FRACTION_BITS + 1;
  localparam int OUT_W  = 3 * DEG_W;
  localparam int M_W    = ((OUT_W + 7) / 8) * 8;
  localparam logic [DEG_W-1:0] DEG_ONE = DEG_W'(1) << FRACTION_BITS;

  // breakpoint registers, one per set
  logic [NUM_SETS-1:0][3*VALUE_BITS-1:0] points;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      points <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        SET_LOW:  points[SET_LOW]  <= cfg_data;
        SET_MID:  points[SET_MID]  <= cfg_data;
        SET_HIGH: points[SET_HIGH] <= cfg_data;
        default:  ;  // no register there, write dropped
      endcase
    end
  end

  // chain links: index 0 is the front stage, index k+1 the output of cell k
  logic                                  chain_valid [CELLS+1];
  logic                                  chain_ready [CELLS+1];
  logic [NUM_SETS-1:0][VALUE_BITS:0]     chain_rem   [CELLS+1];
  logic [NUM_SETS-1:0][VALUE_BITS-1:0]   chain_den   [CELLS+1];
  logic [NUM_SETS-1:0][FRACTION_BITS:0]  chain_quo   [CELLS+1];

  // range tests and slope selection
  fms_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .x         (s_tdata[VALUE_BITS-1:0]),
    .points    (points),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_rem   (chain_rem[0]),
    .out_den   (chain_den[0])
  );

  // quotient starts empty, bits shift in from the right
  assign chain_quo[0] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    fms_cell #(
      .VALUE_BITS    (VALUE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_rem    (chain_rem[k]),
      .in_den    (chain_den[k]),
      .in_quo    (chain_quo[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_rem   (chain_rem[k+1]),
      .out_den   (chain_den[k+1]),
      .out_quo   (chain_quo[k+1])
    );
  end

  assign m_tvalid           = chain_valid[CELLS];
  assign chain_ready[CELLS] = m_tready;
  assign m_tdata            = M_W'({chain_quo[CELLS][SET_HIGH],
                                    chain_quo[CELLS][SET_MID],
                                    chain_quo[CELLS][SET_LOW]});

  // degrees never exceed 1.0
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (chain_quo[CELLS][SET_LOW]  <= DEG_ONE) &&
                 (chain_quo[CELLS][SET_MID]  <= DEG_ONE) &&
                 (chain_quo[CELLS][SET_HIGH] <= DEG_ONE))
    else $error("degree above one");

  // final partial remainder stays below twice the divisor
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (chain_rem[CELLS][SET_LOW]  < {chain_den[CELLS][SET_LOW],  1'b0}) &&
                 (chain_rem[CELLS][SET_MID]  < {chain_den[CELLS][SET_MID],  1'b0}) &&
                 (chain_rem[CELLS][SET_HIGH] < {chain_den[CELLS][SET_HIGH], 1'b0}))
    else $error("divider remainder out of range");

  // an accepting receiver never blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // chain is empty right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the three-set triangular fuzzifier: breakpoints are
// loaded over the cfg channel, crisp values stream in and every degree triple
// coming out is compared against a local fixed-point model of the three sets
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fms_pkg::*;

  localparam int VALUE_BITS    = VALUE_BITS_DEF;
  localparam int FRACTION_BITS = FRACTION_BITS_DEF;
  localparam int DEG_BITS      = FRACTION_BITS + 1;
  localparam int CFG_BITS      = 3 * VALUE_BITS;
  localparam int LATENCY       = FRACTION_BITS + 2;
  localparam int S_BITS        = ((VALUE_BITS + 7) / 8) * 8;
  localparam int M_BITS        = ((3 * DEG_BITS + 7) / 8) * 8;
  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 194;

  localparam logic [DEG_BITS-1:0] UNITY = DEG_BITS'(1) << FRACTION_BITS;
  // cfg index with no register behind it, writes there must be dropped
  localparam logic [REG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [DEG_BITS-1:0] low_deg;
    logic [DEG_BITS-1:0] mid_deg;
    logic [DEG_BITS-1:0] high_deg;
  } degrees_t;

  // one directed stimulus row; typed degrees are used only when known is set
  typedef struct {
    int                  setting;
    logic [15:0]         x;
    bit                  known;
    logic [DEG_BITS-1:0] lo;
    logic [DEG_BITS-1:0] mi;
    logic [DEG_BITS-1:0] hi;
  } row_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [REG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [3*VALUE_BITS-1:0]     cfg_data = '0;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [S_BITS-1:0]           s_tdata = '0;  // crisp_value
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [M_BITS-1:0]           m_tdata;       // low_degree, mid_degree, high_degree

  // local copy of the breakpoint registers: {c, b, a}, a lowest
  logic [3*VALUE_BITS-1:0] set_regs [NUM_SETS] = '{default: '0};
  logic [3*VALUE_BITS-1:0] next_points [NUM_SETS];
  degrees_t                expected_degrees [$];

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int error_count     = 0;
  int values_sent     = 0;
  int triples_checked = 0;
  int settings_used   = 0;

  // breakpoint settings of the directed part; setting 0 is the reset state
  logic [3*VALUE_BITS-1:0] directed_points [5][NUM_SETS] = '{
    '{48'h0, 48'h0, 48'h0},
    // overlapping low / mid / high sets
    '{{16'd200, 16'd100, 16'd0}, {16'd300, 16'd200, 16'd100},
      {16'hFFFF, 16'd300, 16'd200}},
    // extremes of the value range
    '{{16'hFFFF, 16'h0000, 16'h0000}, {16'hFFFF, 16'hFFFF, 16'hFFFF},
      {16'hFFFF, 16'hFFFF, 16'h0000}},
    // every set collapsed to a single point: zero-width slopes
    '{{16'd50, 16'd50, 16'd50}, {16'd60, 16'd60, 16'd60}, {16'd70, 16'd70, 16'd70}},
    // breakpoints in falling order: no range ever matches
    '{{16'd100, 16'd200, 16'd300}, {16'd100, 16'd200, 16'd300},
      {16'd100, 16'd200, 16'd300}}
  };

  row_t directed_rows [DIRECTED_ROWS] = '{
    '{0, 16'h0000, 1, 9'd256, 9'd256, 9'd256},
    '{0, 16'h0001, 1, 9'd0,   9'd0,   9'd0},
    '{0, 16'hFFFF, 1, 9'd0,   9'd0,   9'd0},
    '{1, 16'd0,    1, 9'd256, 9'd0,   9'd0},
    '{1, 16'd150,  1, 9'd128, 9'd128, 9'd0},
    '{1, 16'd200,  1, 9'd0,   9'd256, 9'd0},
    '{1, 16'd250,  1, 9'd0,   9'd128, 9'd128},
    '{1, 16'hFFFF, 1, 9'd0,   9'd0,   9'd256},
    '{1, 16'd133,  0, 9'd0,   9'd0,   9'd0},
    '{1, 16'd299,  0, 9'd0,   9'd0,   9'd0},
    '{1, 16'd301,  0, 9'd0,   9'd0,   9'd0},
    '{2, 16'h0000, 1, 9'd256, 9'd0,   9'd0},
    '{2, 16'hFFFF, 1, 9'd0,   9'd256, 9'd256},
    '{2, 16'h8000, 1, 9'd127, 9'd0,   9'd128},
    '{2, 16'h0001, 0, 9'd0,   9'd0,   9'd0},
    '{3, 16'd50,   1, 9'd256, 9'd0,   9'd0},
    '{3, 16'd60,   1, 9'd0,   9'd256, 9'd0},
    '{3, 16'd70,   1, 9'd0,   9'd0,   9'd256},
    '{3, 16'd49,   1, 9'd0,   9'd0,   9'd0},
    '{4, 16'd150,  1, 9'd0,   9'd0,   9'd0},
    '{4, 16'd250,  1, 9'd0,   9'd0,   9'd0},
    '{4, 16'd300,  0, 9'd0,   9'd0,   9'd0}
  };

  fuzzy_membership_three_sets i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // fixed-point model of the three sets
  // ---------------------------------------------------------------------------

  function automatic bit between(input logic [15:0] x, lo, hi);
    return x >= lo && x <= hi;
  endfunction

  // truncated num/den in Q1.8, a flat slope that is hit counts as full membership
  function automatic logic [DEG_BITS-1:0] ratio_q8(input logic [15:0] num, den);
    logic [23:0] q;
    if (den == 0) return UNITY;
    q = {num, 8'h00} / den;
    if (q > UNITY) q = UNITY;
    return q[DEG_BITS-1:0];
  endfunction

  function automatic degrees_t fuzzify(input logic [15:0] x);
    degrees_t    d;
    logic [15:0] a, b, c;
    // low set: left shoulder, the falling edge is tested first
    {c, b, a} = set_regs[SET_LOW];
    if (between(x, b, c))      d.low_deg = ratio_q8(c - x, c - b);
    else if (between(x, a, b)) d.low_deg = UNITY;
    else                       d.low_deg = '0;
    // middle set: triangle, rising edge wins at the apex
    {c, b, a} = set_regs[SET_MID];
    if (between(x, a, b))      d.mid_deg = ratio_q8(x - a, b - a);
    else if (between(x, b, c)) d.mid_deg = ratio_q8(c - x, c - b);
    else                       d.mid_deg = '0;
    // high set: right shoulder
    {c, b, a} = set_regs[SET_HIGH];
    if (between(x, a, b))      d.high_deg = ratio_q8(x - a, b - a);
    else if (between(x, b, c)) d.high_deg = UNITY;
    else                       d.high_deg = '0;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx,
                           input logic [3*VALUE_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_SETS) set_regs[idx] = data;
    @(negedge clk);
  endtask

  // load next_points into all three sets, plus a write that must be dropped
  task automatic apply_points();
    write_reg(SET_LOW, next_points[SET_LOW]);
    write_reg(SET_MID, next_points[SET_MID]);
    write_reg(SET_HIGH, next_points[SET_HIGH]);
    write_reg(REG_SPARE, CFG_BITS'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_degrees.size() != 0) @(negedge clk);
  endtask

  // one transfer on the input stream; the expectation is queued on acceptance
  task automatic push_value(input logic [15:0] x, input degrees_t exp_deg);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    expected_degrees.push_back(exp_deg);
    values_sent++;
    @(negedge clk);
  endtask

  function automatic logic [3*VALUE_BITS-1:0] sorted_points(input logic [15:0] p, q, r);
    logic [15:0] t;
    if (p > q) begin t = p; p = q; q = t; end
    if (q > r) begin t = q; q = r; r = t; end
    if (p > q) begin t = p; p = q; q = t; end
    return {r, q, p};
  endfunction

  function automatic logic [15:0] extreme_point();
    case ($urandom_range(2))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // breakpoints for one random phase, by style
  function automatic void pick_points(input int style);
    logic [15:0] a, b, c;
    for (int s = 0; s < NUM_SETS; s++) begin
      case (style)
        0: next_points[s] = sorted_points(16'($urandom), 16'($urandom), 16'($urandom));
        1: begin
          // narrow shapes so most values land on a slope
          a = 16'($urandom_range(65535 - 60));
          b = a + 16'($urandom_range(30));
          c = b + 16'($urandom_range(30));
          next_points[s] = {c, b, a};
        end
        2: next_points[s] = CFG_BITS'({$urandom, $urandom});
        default: next_points[s] = {extreme_point(), extreme_point(), extreme_point()};
      endcase
    end
  endfunction

  // crisp values aimed around the configured breakpoints most of the time
  function automatic logic [15:0] pick_crisp();
    int          r;
    int          s;
    logic [15:0] a, b, c, lo, hi;
    r = $urandom_range(99);
    s = $urandom_range(NUM_SETS - 1);
    {c, b, a} = set_regs[s];
    lo = (a < c) ? a : c;
    hi = (a < c) ? c : a;
    if (r < 35) return 16'($urandom);
    if (r < 75) return 16'($urandom_range(hi, lo));
    case ($urandom_range(2))
      0:       return a + 16'($signed($urandom_range(2)) - 1);
      1:       return b + 16'($signed($urandom_range(2)) - 1);
      default: return c + 16'($signed($urandom_range(2)) - 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: ready changes at the falling edge, results checked at the rising
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    degrees_t want;
    logic [DEG_BITS-1:0] got_low, got_mid, got_high;
    if (!rst && m_tvalid && m_tready) begin
      got_low  = m_tdata[0 +: DEG_BITS];
      got_mid  = m_tdata[DEG_BITS +: DEG_BITS];
      got_high = m_tdata[2*DEG_BITS +: DEG_BITS];
      if (expected_degrees.size() == 0) begin
        $error("result transfer with nothing expected: %0d %0d %0d",
               got_low, got_mid, got_high);
        error_count++;
      end else begin
        want = expected_degrees.pop_front();
        triples_checked++;
        if (got_low !== want.low_deg) begin
          $error("low_degree mismatch: expected %0d, got %0d", want.low_deg, got_low);
          error_count++;
        end
        if (got_mid !== want.mid_deg) begin
          $error("mid_degree mismatch: expected %0d, got %0d", want.mid_deg, got_mid);
          error_count++;
        end
        if (got_high !== want.high_deg) begin
          $error("high_degree mismatch: expected %0d, got %0d", want.high_deg, got_high);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int       cur_setting;
    int       idle_mode;
    degrees_t typed;
    logic [15:0] x;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, no idling on the sender, receiver always ready
    cur_setting = 0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_rows[i].setting != cur_setting) begin
        wait_drained();
        cur_setting = directed_rows[i].setting;
        next_points = directed_points[cur_setting];
        apply_points();
      end
      if (directed_rows[i].known) begin
        typed.low_deg  = directed_rows[i].lo;
        typed.mid_deg  = directed_rows[i].mi;
        typed.high_deg = directed_rows[i].hi;
      end else begin
        typed = fuzzify(directed_rows[i].x);
      end
      push_value(directed_rows[i].x, typed);
    end
    wait_drained();

    // random phases: each with fresh breakpoints and its own idling pattern
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick_points(ph % 4);
      apply_points();
      idle_mode = (ph + ph / 4) % 4;
      case (idle_mode)
        0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
        1:       begin sender_idle_pct = 53; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 53; end
        default: begin sender_idle_pct = 17; stall_pct = 17; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then let the whole pipeline empty before going on
        if ((ph == 0 && n == 100) || $urandom_range(199) == 0) wait_drained();
        x = pick_crisp();
        push_value(x, fuzzify(x));
      end
      wait_drained();
    end

    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (4 * LATENCY) @(negedge clk);

    $display("fuzzifier run: %0d crisp values sent, %0d degree triples checked,",
             values_sent, triples_checked);
    $display("  %0d breakpoint settings incl. reset, extremes, flat and unordered sets",
             settings_used + 1);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### fuzzy_membership_three_sets.f
rtl/fms_pkg.sv
rtl/fms_front.sv
rtl/fms_cell.sv
rtl/fuzzy_membership_three_sets.sv
verif/testbench.sv
